// ----- hw/rtl/lltstat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lltstat_pkg
// Shared types and constants for the lcd line timing and status block.
// ----------------------------------------------------------------------------
package lltstat_pkg;

    // payload widths fixed by the interface
    localparam int ELAPSED_W = 7;
    localparam int LINE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int SEL_W     = 4;

    // mode decode thresholds within a visible line
    localparam int SEARCH_END   = 80;
    localparam int TRANSFER_END = 172;

    // lcd mode codes
    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } lcd_mode_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISPLAY_ENABLE    = 2'd0,
        REG_STATUS_IRQ_SELECT = 2'd1,
        REG_COMPARE_LINE      = 2'd2
    } cfg_index_t;

    // bit positions in the status interrupt select register
    localparam int SEL_HBLANK  = 0;
    localparam int SEL_VBLANK  = 1;
    localparam int SEL_SEARCH  = 2;
    localparam int SEL_COMPARE = 3;

endpackage

// ----- hw/rtl/lcd_line_timing_status.sv -----
`timescale 1ns / 1ps
// Pipeline: input register, then result register on the m_ side. Throughput:
// one request per cycle unless m_ready stalls; the only loop is the cycle
// counter and line register, updated by one add, one compare and a mode decode.
// Reset: aresetn (synchronous, active low) clears the counter, line, previous
// mode, configuration registers and both valid flags.
// ----------------------------------------------------------------------------
// lcd_line_timing_status
// Tracks display line timing from elapsed cycle counts and produces the line,
// mode, coincidence flag, interrupt pulses and a draw strobe per request.
// ----------------------------------------------------------------------------
module lcd_line_timing_status #(
    parameter int LINE_CYCLES   = 456,
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [lltstat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lltstat_pkg::CFG_DAT_W-1:0]  cfg_data,
    // request input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lltstat_pkg::ELAPSED_W-1:0]  s_elapsed_cycles,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lltstat_pkg::LINE_W-1:0]     m_current_line,
    output logic [1:0]                         m_lcd_mode,
    output logic                               m_coincidence,
    output logic                               m_vblank_irq,
    output logic                               m_status_irq,
    output logic                               m_draw_strobe,
    output logic [lltstat_pkg::LINE_W-1:0]     m_drawn_line
);

    // counter holds up to one line period plus one maximal elapsed count
    localparam int CNT_W = $clog2(LINE_CYCLES + (1 << lltstat_pkg::ELAPSED_W));
    localparam int LW    = lltstat_pkg::LINE_W;

    localparam logic [CNT_W-1:0] LINE_C     = CNT_W'(LINE_CYCLES);
    localparam logic [CNT_W-1:0] SEARCH_C   = CNT_W'(lltstat_pkg::SEARCH_END);
    localparam logic [CNT_W-1:0] TRANSFER_C = CNT_W'(lltstat_pkg::TRANSFER_END);
    localparam logic [LW-1:0]    VIS_L      = LW'(VISIBLE_LINES);
    localparam logic [LW-1:0]    TOT_L      = LW'(TOTAL_LINES);

    // configuration registers
    logic                            display_enable_reg;
    logic [lltstat_pkg::SEL_W-1:0]   irq_select_reg;
    logic [LW-1:0]                   compare_line_reg;

    // input stage
    logic                                in_valid_reg;
    logic [lltstat_pkg::ELAPSED_W-1:0]   in_elapsed_reg;

    // timing state
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [LW-1:0]           line_reg, line_next;
    lltstat_pkg::lcd_mode_t  prev_mode_reg, prev_mode_next;

    // result stage
    logic                    out_valid_reg;
    logic [LW-1:0]           out_line_reg, out_line_next;
    lltstat_pkg::lcd_mode_t  out_mode_reg, out_mode_next;
    logic                    out_coin_reg, out_coin_next;
    logic                    out_vblank_reg, out_vblank_next;
    logic                    out_stat_reg, out_stat_next;
    logic                    out_strobe_reg, out_strobe_next;
    logic [LW-1:0]           out_drawn_reg, out_drawn_next;

    // datapath intermediates
    logic [CNT_W-1:0]        cnt_sum;
    logic                    line_wrap;
    logic [LW-1:0]           line_inc;
    logic [LW-1:0]           line_adv;
    lltstat_pkg::lcd_mode_t  mode_dec;
    logic                    mode_irq_en;
    logic                    coin_hit;
    logic                    advance;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_enable_reg <= 1'b0;
            irq_select_reg     <= '0;
            compare_line_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lltstat_pkg::REG_DISPLAY_ENABLE:    display_enable_reg <= cfg_data[0];
                lltstat_pkg::REG_STATUS_IRQ_SELECT: irq_select_reg <= cfg_data[lltstat_pkg::SEL_W-1:0];
                lltstat_pkg::REG_COMPARE_LINE:      compare_line_reg <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // counter and line advance
    always_comb begin
        cnt_sum   = cnt_reg + CNT_W'(in_elapsed_reg);
        line_wrap = (cnt_sum >= LINE_C);
        line_inc  = line_reg + LW'(1);
        line_adv  = (line_inc >= TOT_L) ? '0 : line_inc;
    end

    // mode decode on the updated line and counter
    always_comb begin
        cnt_next  = line_wrap ? (cnt_sum - LINE_C) : cnt_sum;
        line_next = line_wrap ? line_adv : line_reg;
        if (line_next >= VIS_L) begin
            mode_dec = lltstat_pkg::MODE_VBLANK;
        end else if (cnt_next <= SEARCH_C) begin
            mode_dec = lltstat_pkg::MODE_SEARCH;
        end else if (cnt_next <= TRANSFER_C) begin
            mode_dec = lltstat_pkg::MODE_TRANSFER;
        end else begin
            mode_dec = lltstat_pkg::MODE_HBLANK;
        end
        case (mode_dec)
            lltstat_pkg::MODE_HBLANK: mode_irq_en = irq_select_reg[lltstat_pkg::SEL_HBLANK];
            lltstat_pkg::MODE_VBLANK: mode_irq_en = irq_select_reg[lltstat_pkg::SEL_VBLANK];
            lltstat_pkg::MODE_SEARCH: mode_irq_en = irq_select_reg[lltstat_pkg::SEL_SEARCH];
            default:                  mode_irq_en = 1'b0;
        endcase
        coin_hit = (line_next == compare_line_reg);
    end

    // result selection, display on or off
    always_comb begin
        if (!display_enable_reg) begin
            out_line_next   = '0;
            out_mode_next   = lltstat_pkg::MODE_VBLANK;
            out_coin_next   = 1'b0;
            out_vblank_next = 1'b0;
            out_stat_next   = 1'b0;
            out_strobe_next = 1'b0;
            out_drawn_next  = '0;
            prev_mode_next  = lltstat_pkg::MODE_VBLANK;
        end else begin
            out_line_next   = line_next;
            out_mode_next   = mode_dec;
            out_coin_next   = coin_hit;
            out_vblank_next = line_wrap && (line_adv == VIS_L);
            out_stat_next   = ((mode_dec != prev_mode_reg) && mode_irq_en)
                            || (coin_hit && irq_select_reg[lltstat_pkg::SEL_COMPARE]);
            out_strobe_next = line_wrap && (line_reg < VIS_L);
            out_drawn_next  = out_strobe_next ? line_reg : '0;
            prev_mode_next  = mode_dec;
        end
    end

    // input register, timing state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            line_reg      <= '0;
            prev_mode_reg <= lltstat_pkg::MODE_HBLANK;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg   <= 1'b1;
                in_elapsed_reg <= s_elapsed_cycles;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                cnt_reg        <= display_enable_reg ? cnt_next : LINE_C;
                line_reg       <= display_enable_reg ? line_next : '0;
                prev_mode_reg  <= prev_mode_next;
                out_line_reg   <= out_line_next;
                out_mode_reg   <= out_mode_next;
                out_coin_reg   <= out_coin_next;
                out_vblank_reg <= out_vblank_next;
                out_stat_reg   <= out_stat_next;
                out_strobe_reg <= out_strobe_next;
                out_drawn_reg  <= out_drawn_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output ports
    assign m_valid        = out_valid_reg;
    assign m_current_line = out_line_reg;
    assign m_lcd_mode     = out_mode_reg;
    assign m_coincidence  = out_coin_reg;
    assign m_vblank_irq   = out_vblank_reg;
    assign m_status_irq   = out_stat_reg;
    assign m_draw_strobe  = out_strobe_reg;
    assign m_drawn_line   = out_drawn_reg;

    // counter never exceeds one line period
    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= LINE_C)
        else $error("cycle counter above line period");

    // line stays inside the frame
    assert property (@(posedge aclk) disable iff (!aresetn) line_reg < TOT_L)
        else $error("line number past total lines");

    // vblank pulse only on entering the first non-visible line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_vblank_irq) |->
            (m_current_line == VIS_L) && (m_lcd_mode == lltstat_pkg::MODE_VBLANK))
        else $error("vblank pulse on wrong line or mode");

    // draw strobe names a visible line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_draw_strobe) |-> (m_drawn_line < VIS_L))
        else $error("draw strobe for non-visible line");

    // a processed request lands in the result register next cycle
    assert property (@(posedge aclk) disable iff (!aresetn) advance |=> out_valid_reg)
        else $error("result lost after advance");

endmodule

// ----- dv/lcd_line_timing_status_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_line_timing_status_test
// Drives elapsed cycle counts into the line timing block and checks every
// status result against a cycle-exact line, mode and interrupt predictor.
// Runs under random stalls on both channels and under several register
// settings, including display blanking and line advances with carry.
// ----------------------------------------------------------------------------
module lcd_line_timing_status_test;

    localparam int LINE_CYCLES   = 456;
    localparam int VISIBLE_LINES = 144;
    localparam int TOTAL_LINES   = 154;

    // one status result as the block reports it
    typedef struct packed {
        logic [lltstat_pkg::LINE_W-1:0] current_line;
        lltstat_pkg::lcd_mode_t         lcd_mode;
        logic                           coincidence;
        logic                           vblank_irq;
        logic                           status_irq;
        logic                           draw_strobe;
        logic [lltstat_pkg::LINE_W-1:0] drawn_line;
    } line_status_t;

    logic                              aclk             = 1'b0;
    logic                              aresetn          = 1'b0;
    logic                              cfg_wr_en        = 1'b0;
    logic [lltstat_pkg::CFG_IDX_W-1:0] cfg_index        = '0;
    logic [lltstat_pkg::CFG_DAT_W-1:0] cfg_data         = '0;
    logic                              s_valid          = 1'b0;
    logic                              s_ready;
    logic [lltstat_pkg::ELAPSED_W-1:0] s_elapsed_cycles = '0;
    logic                              m_valid;
    logic                              m_ready          = 1'b0;
    logic [lltstat_pkg::LINE_W-1:0]    m_current_line;
    logic [1:0]                        m_lcd_mode;
    logic                              m_coincidence;
    logic                              m_vblank_irq;
    logic                              m_status_irq;
    logic                              m_draw_strobe;
    logic [lltstat_pkg::LINE_W-1:0]    m_drawn_line;

    // predictor copy of the registers and timing state
    logic                           cfg_enable   = 1'b0;
    logic [lltstat_pkg::SEL_W-1:0]  cfg_select   = '0;
    logic [lltstat_pkg::LINE_W-1:0] cfg_compare  = '0;
    logic [9:0]                     tm_count     = '0;
    logic [lltstat_pkg::LINE_W-1:0] tm_line      = '0;
    lltstat_pkg::lcd_mode_t         tm_prev_mode = lltstat_pkg::MODE_HBLANK;

    line_status_t pending_status[$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;

    lcd_line_timing_status #(
        .LINE_CYCLES   (LINE_CYCLES),
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_elapsed_cycles (s_elapsed_cycles),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_current_line   (m_current_line),
        .m_lcd_mode       (m_lcd_mode),
        .m_coincidence    (m_coincidence),
        .m_vblank_irq     (m_vblank_irq),
        .m_status_irq     (m_status_irq),
        .m_draw_strobe    (m_draw_strobe),
        .m_drawn_line     (m_drawn_line)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("lcd_line_timing_status verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // advance the line timing by one accepted request and queue its status
    task automatic advance_line_timing(input logic [lltstat_pkg::ELAPSED_W-1:0] elapsed);
        line_status_t           want;
        int                     sum;
        int                     next_line;
        lltstat_pkg::lcd_mode_t md;
        logic                   sel_bit;
        want = '0;
        if (!cfg_enable) begin
            // display off: held at line zero in vblank, counter preset
            tm_line       = '0;
            tm_prev_mode  = lltstat_pkg::MODE_VBLANK;
            tm_count      = 10'(LINE_CYCLES);
            want.lcd_mode = lltstat_pkg::MODE_VBLANK;
        end else begin
            sum = int'(tm_count) + int'(elapsed);
            // at most one line per request, excess carried over
            if (sum >= LINE_CYCLES) begin
                if (tm_line < VISIBLE_LINES) begin
                    want.draw_strobe = 1'b1;
                    want.drawn_line  = tm_line;
                end
                next_line = int'(tm_line) + 1;
                if (next_line >= TOTAL_LINES)
                    next_line = 0;
                if (next_line == VISIBLE_LINES)
                    want.vblank_irq = 1'b1;
                tm_line = lltstat_pkg::LINE_W'(next_line);
                sum -= LINE_CYCLES;
            end
            tm_count = 10'(sum);

            // mode decode
            if (tm_line >= VISIBLE_LINES)
                md = lltstat_pkg::MODE_VBLANK;
            else if (tm_count <= lltstat_pkg::SEARCH_END)
                md = lltstat_pkg::MODE_SEARCH;
            else if (tm_count <= lltstat_pkg::TRANSFER_END)
                md = lltstat_pkg::MODE_TRANSFER;
            else
                md = lltstat_pkg::MODE_HBLANK;

            // mode change interrupt, transfer has no enable
            case (md)
                lltstat_pkg::MODE_HBLANK: sel_bit = cfg_select[lltstat_pkg::SEL_HBLANK];
                lltstat_pkg::MODE_VBLANK: sel_bit = cfg_select[lltstat_pkg::SEL_VBLANK];
                lltstat_pkg::MODE_SEARCH: sel_bit = cfg_select[lltstat_pkg::SEL_SEARCH];
                default:                  sel_bit = 1'b0;
            endcase
            if (md != tm_prev_mode && sel_bit)
                want.status_irq = 1'b1;
            tm_prev_mode = md;

            // coincidence is a level, interrupt fires every request it holds
            if (tm_line == cfg_compare) begin
                want.coincidence = 1'b1;
                if (cfg_select[lltstat_pkg::SEL_COMPARE])
                    want.status_irq = 1'b1;
            end
            want.current_line = tm_line;
            want.lcd_mode     = md;
        end
        pending_status.push_back(want);
    endtask

    // present one request, idling at random first
    task automatic send_request(input logic [lltstat_pkg::ELAPSED_W-1:0] elapsed);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_elapsed_cycles <= elapsed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_line_timing(elapsed);
    endtask

    // stop sending and wait for every queued status
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_register(input lltstat_pkg::cfg_index_t idx,
                                  input logic [lltstat_pkg::CFG_DAT_W-1:0] value);
        wait_drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            lltstat_pkg::REG_DISPLAY_ENABLE:    cfg_enable  = value[0];
            lltstat_pkg::REG_STATUS_IRQ_SELECT: cfg_select  = value[lltstat_pkg::SEL_W-1:0];
            lltstat_pkg::REG_COMPARE_LINE:      cfg_compare = value;
            default: ;
        endcase
    endtask

    // display off: input ignored, flags cleared even when line matches
    task automatic test_display_off();
        send_request(7'd0);
        send_request(7'd80);
        write_register(lltstat_pkg::REG_STATUS_IRQ_SELECT, 8'hFF);
        write_register(lltstat_pkg::REG_COMPARE_LINE, 8'h00);
        send_request(7'd80);
    endtask

    // first request after enable completes line zero at once
    task automatic test_enable_start();
        write_register(lltstat_pkg::REG_DISPLAY_ENABLE, 8'h01);
        send_request(7'd0);
    endtask

    // walk one line through search, transfer and hblank boundaries
    task automatic test_mode_walk();
        write_register(lltstat_pkg::REG_COMPARE_LINE, 8'd1);
        write_register(lltstat_pkg::REG_STATUS_IRQ_SELECT, 8'h08);
        send_request(7'd40);
        send_request(7'd40);
        send_request(7'd1);
        send_request(7'd80);
        send_request(7'd11);
        send_request(7'd1);
        send_request(7'd80);
        send_request(7'd80);
        send_request(7'd80);
        send_request(7'd43);
        // overshoot of the line period carries into the next line
        write_register(lltstat_pkg::REG_STATUS_IRQ_SELECT, 8'h05);
        repeat (6) send_request(7'd80);
        // transfer entry raises nothing even with all mode enables
        write_register(lltstat_pkg::REG_STATUS_IRQ_SELECT, 8'h07);
        send_request(7'd80);
        send_request(7'd80);
    endtask

    // random register settings, each followed by a burst of requests
    task automatic test_random_settings(input int n_items);
        int                                sent;
        logic [lltstat_pkg::CFG_DAT_W-1:0] sel;
        logic [lltstat_pkg::CFG_DAT_W-1:0] cmp;
        logic [lltstat_pkg::ELAPSED_W-1:0] el;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(3))
                0:       sel = 8'h00;
                1:       sel = 8'hFF;
                default: sel = 8'($urandom);
            endcase
            case ($urandom_range(4))
                0:       cmp = 8'hFF;
                1:       cmp = 8'h00;
                2:       cmp = 8'($urandom);
                default: cmp = 8'($urandom_range(12));
            endcase
            write_register(lltstat_pkg::REG_STATUS_IRQ_SELECT, sel);
            write_register(lltstat_pkg::REG_COMPARE_LINE, cmp);
            // sometimes blank the display, then bring it back
            if ($urandom_range(3) == 0) begin
                write_register(lltstat_pkg::REG_DISPLAY_ENABLE, {7'($urandom), 1'b0});
                repeat ($urandom_range(1, 3)) begin
                    send_request(7'($urandom_range(80)));
                    sent++;
                end
            end
            write_register(lltstat_pkg::REG_DISPLAY_ENABLE, {7'($urandom), 1'b1});
            repeat ($urandom_range(20, 45)) begin
                if ($urandom_range(24) == 0)
                    wait_drain();
                case ($urandom_range(5))
                    0:       el = 7'd0;
                    1:       el = 7'd80;
                    default: el = 7'($urandom_range(80));
                endcase
                send_request(el);
                sent++;
            end
        end
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result with the oldest expected status
    always @(posedge aclk) begin : check_results
        line_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("result with no pending request");
            end else begin
                want = pending_status.pop_front();
                if (m_current_line !== want.current_line)
                    report_mismatch($sformatf("current_line got %0d expected %0d",
                        m_current_line, want.current_line));
                if (m_lcd_mode !== want.lcd_mode)
                    report_mismatch($sformatf("lcd_mode got %0d expected %0d",
                        m_lcd_mode, want.lcd_mode));
                if (m_coincidence !== want.coincidence)
                    report_mismatch($sformatf("coincidence got %0b expected %0b",
                        m_coincidence, want.coincidence));
                if (m_vblank_irq !== want.vblank_irq)
                    report_mismatch($sformatf("vblank_irq got %0b expected %0b",
                        m_vblank_irq, want.vblank_irq));
                if (m_status_irq !== want.status_irq)
                    report_mismatch($sformatf("status_irq got %0b expected %0b",
                        m_status_irq, want.status_irq));
                if (m_draw_strobe !== want.draw_strobe)
                    report_mismatch($sformatf("draw_strobe got %0b expected %0b",
                        m_draw_strobe, want.draw_strobe));
                if (m_drawn_line !== want.drawn_line)
                    report_mismatch($sformatf("drawn_line got %0d expected %0d",
                        m_drawn_line, want.drawn_line));
            end
        end
    end

    // test sequence
    initial begin : run_tests
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 81;
        test_display_off();
        test_enable_start();
        test_mode_walk();
        test_random_settings(120);

        send_idle_pct = 81;
        recv_idle_pct = 31;
        test_random_settings(120);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_settings(120);

        wait_drain();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("lcd_line_timing_status verification clean");
        end else begin
            $display("lcd_line_timing_status verification failed");
        end
        $finish;
    end

endmodule
